// File: hdl/tle_pkg.sv
// Shared constants and types of the terminal line editor.
package tle_pkg;
   localparam int LINE_CAPACITY = 512;
   localparam int ADDR_W = $clog2(LINE_CAPACITY);
   localparam int LEN_W = $clog2(LINE_CAPACITY + 1);
   localparam int LEN_PORT_W = 10;
   localparam int IDX_W = 9;

   localparam logic [7:0] CH_ESC = 8'h1B;
   localparam logic [7:0] CH_BS = 8'h08;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_THREE = 8'h33;
   localparam logic [7:0] CH_TILDE = 8'h7E;
   localparam logic [7:0] CH_UP_D = 8'h44;
   localparam logic [7:0] CH_UP_C = 8'h43;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic OP_RX = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_INSERT,
      ACT_BKSP,
      ACT_LEFT,
      ACT_RIGHT,
      ACT_DELETE,
      ACT_DONE,
      ACT_READ
   } action_type;

   // One classified word handed from the front to the back.
   typedef struct packed {
      action_type       action;
      logic             ins_bracket;
      logic             ins_three;
      logic [7:0]       ch;
      logic [IDX_W-1:0] idx;
   } desc_type;
endpackage

// File: hdl/tle_ifs.sv
// Request and response channel interfaces.
interface tle_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] rx_byte;
   logic [8:0] read_index;
   modport source (output valid, operation, rx_byte, read_index, input ready);
   modport sink (input valid, operation, rx_byte, read_index, output ready);
endinterface

interface tle_rsp_if;
   logic       valid;
   logic       ready;
   logic [9:0] line_length;
   logic [9:0] cursor;
   logic       changed;
   logic       line_done;
   logic [7:0] read_char;
   modport source (output valid, line_length, cursor, changed, line_done, read_char,
                   input ready);
   modport sink (input valid, line_length, cursor, changed, line_done, read_char,
                 output ready);
endinterface

// File: hdl/tle_ram.sv
// Generic simple dual-port RAM with registered read.
module tle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hdl/tle_queue.sv
// Two-entry queue of classified words between front and back.
module tle_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tle_pkg::desc_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output tle_pkg::desc_type pop_data
);
   import tle_pkg::*;

   desc_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full = count_ff[1];
   assign not_empty = (count_ff != 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];
endmodule

// File: hdl/tle_front.sv
// Front end: accepts words, tracks escape matching and classifies each word.
module tle_front (
   input  logic              clock,
   input  logic              reset,
   tle_req_if.sink           req,
   input  logic              q_full,
   output logic              q_push,
   output tle_pkg::desc_type q_data
);
   import tle_pkg::*;

   typedef enum logic [1:0] {ESC_IDLE, ESC_HELD, ESC_BRACKET, ESC_THREE} esc_type;

   esc_type  esc_ff, esc_in;
   desc_type desc;
   logic     ordinary;

   assign req.ready = !q_full;
   assign q_push = req.valid && !q_full;

   always_comb begin
      esc_in = esc_ff;
      ordinary = 1'b0;
      desc.action = ACT_NONE;
      desc.ins_bracket = 1'b0;
      desc.ins_three = 1'b0;
      desc.ch = req.rx_byte;
      desc.idx = req.read_index;
      if (req.operation == OP_READ) begin
         desc.action = ACT_READ;
      end else begin
         ordinary = 1'b1;
         if (esc_ff == ESC_HELD && req.rx_byte == CH_LBRACK) begin
            esc_in = ESC_BRACKET;
            ordinary = 1'b0;
         end else if (esc_ff == ESC_BRACKET && req.rx_byte == CH_UP_D) begin
            desc.action = ACT_LEFT;
            esc_in = ESC_IDLE;
            ordinary = 1'b0;
         end else if (esc_ff == ESC_BRACKET && req.rx_byte == CH_UP_C) begin
            desc.action = ACT_RIGHT;
            esc_in = ESC_IDLE;
            ordinary = 1'b0;
         end else if (esc_ff == ESC_BRACKET && req.rx_byte == CH_THREE) begin
            esc_in = ESC_THREE;
            ordinary = 1'b0;
         end else if (esc_ff == ESC_THREE && req.rx_byte == CH_TILDE) begin
            desc.action = ACT_DELETE;
            esc_in = ESC_IDLE;
            ordinary = 1'b0;
         end else if (esc_ff != ESC_IDLE) begin
            // unmatched: replay the held bytes after the ESC
            desc.ins_bracket = (esc_ff == ESC_BRACKET) || (esc_ff == ESC_THREE);
            desc.ins_three = (esc_ff == ESC_THREE);
            esc_in = ESC_IDLE;
         end
         if (ordinary) begin
            if (req.rx_byte == CH_ESC) begin
               esc_in = ESC_HELD;
            end else if (req.rx_byte >= CH_SPACE && req.rx_byte < 8'h7F) begin
               desc.action = ACT_INSERT;
            end else if (req.rx_byte == CH_BS) begin
               desc.action = ACT_BKSP;
            end else if (req.rx_byte == CH_CR || req.rx_byte == CH_LF) begin
               desc.action = ACT_DONE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff <= ESC_IDLE;
      end else if (q_push) begin
         esc_ff <= esc_in;
      end
   end

   assign q_data = desc;
endmodule

// File: hdl/tle_back.sv
// Back end: carries out edits on the line store and returns one response word.
module tle_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_not_empty,
   input  tle_pkg::desc_type q_data,
   output logic              q_pop,
   tle_rsp_if.source         rsp
);
   import tle_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_STEP, S_SHIFT, S_DRAIN, S_PUTCH, S_READ, S_RESP}
      state_type;

   localparam logic [LEN_W-1:0] CAP = LEN_W'(LINE_CAPACITY);
   localparam logic [LEN_W-1:0] ONE = LEN_W'(1);

   state_type         state_ff, state_in;
   desc_type          desc_ff, desc_in;
   logic [1:0]        phase_ff, phase_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  cur_ff, cur_in;
   logic [LEN_W-1:0]  done_len_ff, done_len_in;
   logic              changed_ff, changed_in;
   logic              done_ff, done_in;
   logic [7:0]        rchar_ff, rchar_in;
   logic [ADDR_W-1:0] src_ff, src_in;
   logic [LEN_W-1:0]  left_ff, left_in;
   logic              up_ff, up_in;
   logic              put_ff, put_in;
   logic [7:0]        ch_ff, ch_in;
   logic [ADDR_W-1:0] put_addr_ff, put_addr_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [LEN_W-1:0]  rsp_len_ff, rsp_len_in;
   logic [LEN_W-1:0]  rsp_cur_ff, rsp_cur_in;
   logic              rsp_changed_ff, rsp_changed_in;
   logic              rsp_done_ff, rsp_done_in;
   logic [7:0]        rsp_char_ff, rsp_char_in;

   logic              do_insert;
   logic [7:0]        ins_ch;
   logic [LEN_W-1:0]  new_cur;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [7:0]        wr_data, rd_data;

   tle_ram #(.WIDTH(8), .DEPTH(LINE_CAPACITY)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign wr_en = pend_ff || (state_ff == S_PUTCH);
   assign wr_addr = pend_ff ? pend_addr_ff : put_addr_ff;
   assign wr_data = pend_ff ? rd_data : ch_ff;
   assign rd_addr = (state_ff == S_SHIFT) ? src_ff : ADDR_W'(desc_ff.idx);
   assign q_pop = (state_ff == S_IDLE) && q_not_empty;

   always_comb begin
      state_in = state_ff;
      desc_in = desc_ff;
      phase_in = phase_ff;
      len_in = len_ff;
      cur_in = cur_ff;
      done_len_in = done_len_ff;
      changed_in = changed_ff;
      done_in = done_ff;
      rchar_in = rchar_ff;
      src_in = src_ff;
      left_in = left_ff;
      up_in = up_ff;
      put_in = put_ff;
      ch_in = ch_ff;
      put_addr_in = put_addr_ff;
      pend_in = 1'b0;
      pend_addr_in = pend_addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_len_in = rsp_len_ff;
      rsp_cur_in = rsp_cur_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_done_in = rsp_done_ff;
      rsp_char_in = rsp_char_ff;
      do_insert = 1'b0;
      ins_ch = desc_ff.ch;
      new_cur = cur_ff - ONE;

      case (state_ff)
         S_IDLE: begin
            if (q_not_empty) begin
               desc_in = q_data;
               phase_in = 2'd0;
               changed_in = 1'b0;
               done_in = 1'b0;
               rchar_in = 8'd0;
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            phase_in = phase_ff + 2'd1;
            case (phase_ff)
               2'd0: begin
                  do_insert = desc_ff.ins_bracket;
                  ins_ch = CH_LBRACK;
               end
               2'd1: begin
                  do_insert = desc_ff.ins_three;
                  ins_ch = CH_THREE;
               end
               2'd2: begin
                  case (desc_ff.action)
                     ACT_INSERT: do_insert = 1'b1;
                     ACT_BKSP: begin
                        if (cur_ff != '0) begin
                           changed_in = 1'b1;
                           cur_in = new_cur;
                           len_in = len_ff - ONE;
                           src_in = ADDR_W'(cur_ff);
                           left_in = len_ff - ONE - new_cur;
                           up_in = 1'b0;
                           put_in = 1'b0;
                           if (len_ff - ONE != new_cur) begin
                              state_in = S_SHIFT;
                           end
                        end
                     end
                     ACT_DELETE: begin
                        if (cur_ff < len_ff) begin
                           changed_in = 1'b1;
                           len_in = len_ff - ONE;
                           src_in = ADDR_W'(cur_ff + ONE);
                           left_in = len_ff - ONE - cur_ff;
                           up_in = 1'b0;
                           put_in = 1'b0;
                           if (len_ff - ONE != cur_ff) begin
                              state_in = S_SHIFT;
                           end
                        end
                     end
                     ACT_LEFT: begin
                        if (cur_ff != '0) begin
                           changed_in = 1'b1;
                           cur_in = new_cur;
                        end
                     end
                     ACT_RIGHT: begin
                        if (cur_ff < len_ff) begin
                           changed_in = 1'b1;
                           cur_in = cur_ff + ONE;
                        end
                     end
                     ACT_DONE: begin
                        done_in = 1'b1;
                        done_len_in = len_ff;
                        len_in = '0;
                        cur_in = '0;
                     end
                     ACT_READ: begin
                        if ({1'b0, desc_ff.idx} < (IDX_W + 1)'(LINE_CAPACITY)) begin
                           state_in = S_READ;
                        end
                     end
                     default: ;
                  endcase
               end
               default: state_in = S_RESP;
            endcase
            if (do_insert && len_ff < CAP) begin
               changed_in = 1'b1;
               ch_in = ins_ch;
               put_addr_in = ADDR_W'(cur_ff);
               put_in = 1'b1;
               cur_in = cur_ff + ONE;
               len_in = len_ff + ONE;
               src_in = ADDR_W'(len_ff - ONE);
               left_in = len_ff - cur_ff;
               up_in = 1'b1;
               state_in = (len_ff != cur_ff) ? S_SHIFT : S_PUTCH;
            end
         end
         S_SHIFT: begin
            pend_in = 1'b1;
            pend_addr_in = up_ff ? src_ff + ADDR_W'(1) : src_ff - ADDR_W'(1);
            src_in = up_ff ? src_ff - ADDR_W'(1) : src_ff + ADDR_W'(1);
            left_in = left_ff - ONE;
            if (left_ff == ONE) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: state_in = put_ff ? S_PUTCH : S_STEP;
         S_PUTCH: state_in = S_STEP;
         S_READ: begin
            rchar_in = rd_data;
            state_in = S_STEP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_len_in = done_ff ? done_len_ff : len_ff;
               rsp_cur_in = cur_ff;
               rsp_changed_in = changed_ff;
               rsp_done_in = done_ff;
               rsp_char_in = rchar_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         len_ff <= '0;
         cur_ff <= '0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff <= len_in;
         cur_ff <= cur_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      desc_ff <= desc_in;
      phase_ff <= phase_in;
      done_len_ff <= done_len_in;
      changed_ff <= changed_in;
      done_ff <= done_in;
      rchar_ff <= rchar_in;
      src_ff <= src_in;
      left_ff <= left_in;
      up_ff <= up_in;
      put_ff <= put_in;
      ch_ff <= ch_in;
      put_addr_ff <= put_addr_in;
      pend_addr_ff <= pend_addr_in;
      rsp_len_ff <= rsp_len_in;
      rsp_cur_ff <= rsp_cur_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_done_ff <= rsp_done_in;
      rsp_char_ff <= rsp_char_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.line_length = LEN_PORT_W'(rsp_len_ff);
   assign rsp.cursor = LEN_PORT_W'(rsp_cur_ff);
   assign rsp.changed = rsp_changed_ff;
   assign rsp.line_done = rsp_done_ff;
   assign rsp.read_char = rsp_char_ff;
endmodule

// File: hdl/terminal_line_editor.sv
// Top level of the terminal line editor.
// Each request word is either a received byte or a read of the stored line.
// A small front end follows escape sequences and classifies bytes at one word
// per cycle, while the queue is not full, into a two-entry queue; the back
// end applies the edits to a single-port-read line store, one word at a time.
// An insert or delete shifts the tail of the line one character per cycle.
// Up to three inserts occur when an unmatched escape replays held bytes.
// One response word is returned per request word, in order; the store needs
// no clearing after reset.
module terminal_line_editor (
   input  logic      clock,
   input  logic      reset,
   tle_req_if.sink   req,
   tle_rsp_if.source rsp
);
   import tle_pkg::*;

   desc_type push_data, pop_data;
   logic     push, full, pop, not_empty;

   tle_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .q_full (full),
      .q_push (push),
      .q_data (push_data)
   );

   tle_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_data  (pop_data)
   );

   tle_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (not_empty),
      .q_data      (pop_data),
      .q_pop       (pop),
      .rsp         (rsp)
   );
endmodule
